### sv/tplr_pkg.sv
// Shared types and constants for the tracking packet and line receiver.
`timescale 1ns / 1ps

package tplr_pkg;

   // Field widths fixed by the request and response formats.
   localparam int REQ_TYPE_W = 2;
   localparam int DATA_W     = 8;
   localparam int IDX_W      = 7;
   localparam int COORD_W    = 16;
   localparam int COUNT_W    = 7;
   localparam int TALLY_W    = 16;

   // Framing and text control bytes.
   localparam logic [DATA_W-1:0] HDR_FIRST  = 8'hFF;
   localparam logic [DATA_W-1:0] HDR_SECOND = 8'hAA;
   localparam logic [DATA_W-1:0] TRAILER    = 8'h55;
   localparam logic [DATA_W-1:0] CH_CR      = 8'h0D;
   localparam logic [DATA_W-1:0] CH_LF      = 8'h0A;

   // Request codes carried on req_type.
   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_BYTE    = 2'd0,
      REQ_TAKE    = 2'd1,
      REQ_READ    = 2'd2,
      REQ_RELEASE = 2'd3
   } req_kind_type;

   // Deframer phases, one-hot.
   typedef enum logic [7:0] {
      PH_HUNT = 8'b0000_0001,
      PH_HDR2 = 8'b0000_0010,
      PH_XH   = 8'b0000_0100,
      PH_XL   = 8'b0000_1000,
      PH_YH   = 8'b0001_0000,
      PH_YL   = 8'b0010_0000,
      PH_SUM  = 8'b0100_0000,
      PH_TAIL = 8'b1000_0000
   } phase_type;

   // Commands from the top level to the deframer.
   typedef struct packed {
      logic              byte_en;
      logic              take;
      logic [DATA_W-1:0] data;
   } frame_cmd_type;

   // Deframer status seen by the top level.
   typedef struct packed {
      logic                consumed;
      logic                full;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [TALLY_W-1:0]  tally_next;
   } frame_stat_type;

   // Commands from the top level to the line store.
   typedef struct packed {
      logic              byte_en;
      logic              release_line;
      logic              clear_flag;
      logic [DATA_W-1:0] data;
   } line_cmd_type;

   // Line store status seen by the top level.
   typedef struct packed {
      logic               done_next;
      logic [COUNT_W-1:0] count_next;
      logic               ovf_now;
      logic               ovf_next;
      logic [DATA_W-1:0]  rd_char;
   } line_stat_type;

endpackage

### sv/tplr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module tplr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 96
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds while rd_en is low.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### sv/tplr_deframer.sv
// Packet deframer with checksum check, one-deep coordinate mailbox and error counter.
`timescale 1ns / 1ps

module tplr_deframer
   import tplr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  frame_cmd_type  cmd,
   output frame_stat_type stat
);

   phase_type          phase_ff, phase_in;
   logic [DATA_W-1:0]  xh_ff, xl_ff, yh_ff, yl_ff, sum_ff;
   logic               full_ff, full_in;
   logic [COORD_W-1:0] mbox_x_ff, mbox_x_in, mbox_y_ff, mbox_y_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;
   logic [DATA_W-1:0]  calc_sum;
   logic               frame_good;

   assign calc_sum   = xh_ff + xl_ff + yh_ff + yl_ff;
   assign frame_good = (cmd.data == TRAILER) && (calc_sum == sum_ff);

   // Phase sequencing and mailbox update for one byte beat or take request.
   always_comb begin
      phase_in  = phase_ff;
      full_in   = full_ff;
      mbox_x_in = mbox_x_ff;
      mbox_y_in = mbox_y_ff;
      tally_in  = tally_ff;
      if (cmd.byte_en) begin
         case (phase_ff)
            PH_HUNT: phase_in = (cmd.data == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
            PH_HDR2: begin
               if (cmd.data == HDR_SECOND) begin
                  phase_in = PH_XH;
               end else if (cmd.data == HDR_FIRST) begin
                  phase_in = PH_HDR2;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_XH:   phase_in = PH_XL;
            PH_XL:   phase_in = PH_YH;
            PH_YH:   phase_in = PH_YL;
            PH_YL:   phase_in = PH_SUM;
            PH_SUM:  phase_in = PH_TAIL;
            PH_TAIL: begin
               phase_in = PH_HUNT;
               if (frame_good) begin
                  if (!full_ff) begin
                     mbox_x_in = {xh_ff, xl_ff};
                     mbox_y_in = {yh_ff, yl_ff};
                     full_in   = 1'b1;
                  end
               end else begin
                  tally_in = tally_ff + TALLY_W'(1);
               end
            end
            default: phase_in = PH_HUNT;
         endcase
      end else if (cmd.take) begin
         full_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         full_ff  <= 1'b0;
         tally_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         full_ff  <= full_in;
         tally_ff <= tally_in;
      end
   end

   // Frame byte capture and mailbox payload.
   always_ff @(posedge clock) begin
      mbox_x_ff <= mbox_x_in;
      mbox_y_ff <= mbox_y_in;
      if (cmd.byte_en) begin
         if (phase_ff == PH_XH)  xh_ff  <= cmd.data;
         if (phase_ff == PH_XL)  xl_ff  <= cmd.data;
         if (phase_ff == PH_YH)  yh_ff  <= cmd.data;
         if (phase_ff == PH_YL)  yl_ff  <= cmd.data;
         if (phase_ff == PH_SUM) sum_ff <= cmd.data;
      end
   end

   // Only a byte seen while hunting and not a first header is passed on.
   assign stat.consumed   = (phase_ff != PH_HUNT) || (cmd.data == HDR_FIRST);
   assign stat.full       = full_ff;
   assign stat.x          = mbox_x_ff;
   assign stat.y          = mbox_y_ff;
   assign stat.tally_next = tally_in;

   // The mailbox empties only through a take request or reset.
   assert property (@(posedge clock) disable iff (reset)
      $fell(full_ff) |-> ($past(cmd.take) || $past(reset)))
      else $error("mailbox emptied without a take request");

endmodule

### sv/tplr_line_store.sv
// Text line assembly: line buffer RAM, fill tracking, completion and overflow flags.
`timescale 1ns / 1ps

module tplr_line_store
   import tplr_pkg::*;
#(
   parameter int LINE_DEPTH = 96
) (
   input  logic              clock,
   input  logic              reset,
   input  line_cmd_type      cmd,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_index,
   input  logic [IDX_W-1:0]  held_index,
   output line_stat_type     stat
);

   localparam int AW = $clog2(LINE_DEPTH);
   localparam int CW = IDX_W + AW + 1;

   logic [AW-1:0]     fill_ff, fill_in;
   logic [AW-1:0]     fin_len_ff, fin_len_in;
   logic              ready_ff, ready_in;
   logic              ovf_ff, ovf_in;
   logic              wr_en;
   logic [DATA_W-1:0] ram_q;
   logic              byp_hit_ff;
   logic [DATA_W-1:0] byp_data_ff;
   logic              in_range;

   // Line assembly for one forwarded byte, release and flag clear.
   always_comb begin
      fill_in    = fill_ff;
      fin_len_in = fin_len_ff;
      ready_in   = ready_ff;
      ovf_in     = ovf_ff;
      wr_en      = 1'b0;
      if (cmd.byte_en) begin
         if (cmd.data == CH_CR) begin
            fill_in = fill_ff;
         end else if (cmd.data == CH_LF) begin
            if ((fill_ff != '0) && !ready_ff) begin
               fin_len_in = fill_ff;
               ready_in   = 1'b1;
            end
            fill_in = '0;
         end else if (!ready_ff) begin
            if (fill_ff < AW'(LINE_DEPTH - 1)) begin
               wr_en   = 1'b1;
               fill_in = fill_ff + AW'(1);
            end else begin
               ovf_in  = 1'b1;
               fill_in = '0;
            end
         end
      end
      if (cmd.release_line) begin
         ready_in = 1'b0;
      end
      if (cmd.clear_flag) begin
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         fin_len_ff <= '0;
         ready_ff   <= 1'b0;
         ovf_ff     <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         fin_len_ff <= fin_len_in;
         ready_ff   <= ready_in;
         ovf_ff     <= ovf_in;
      end
   end

   tplr_ram #(
      .WIDTH (DATA_W),
      .DEPTH (LINE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff),
      .wr_data (cmd.data),
      .rd_en   (rd_en),
      .rd_addr (AW'(rd_index)),
      .rd_data (ram_q)
   );

   // A read issued in the same cycle as a write to that entry takes the new byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_hit_ff <= 1'b0;
      end else if (rd_en) begin
         byp_hit_ff <= wr_en && (fill_ff == AW'(rd_index));
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         byp_data_ff <= cmd.data;
      end
   end

   assign in_range = CW'(held_index) < CW'(LINE_DEPTH);

   assign stat.done_next  = ready_in;
   assign stat.count_next = ready_in ? COUNT_W'(fin_len_in) : '0;
   assign stat.ovf_now    = ovf_ff;
   assign stat.ovf_next   = ovf_in;
   assign stat.rd_char    = !in_range ? '0 : (byp_hit_ff ? byp_data_ff : ram_q);

   // The fill count never passes the last usable position.
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= AW'(LINE_DEPTH - 1))
      else $error("line fill count out of range");

   // A completed line always has at least one character.
   assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (fin_len_ff != '0))
      else $error("empty line marked complete");

endmodule

### sv/tracking_packet_and_line_receiver.sv
// Top level of the tracking packet and text line receiver.
`timescale 1ns / 1ps

// Usage:
// The request channel (req_valid/req_ready) carries one beat per received serial
// byte or software access: req_type selects a received byte, a packet take, a line
// byte read at req_line_index, or a line release. Every request beat produces
// exactly one response beat on the rsp channel (rsp_valid/rsp_ready).
// An accepted request is captured in the input register, then processed into the
// response register once that register is free; its response is valid from there.
// Throughput: one beat per cycle; the input register and the response register
// are separate, and the line buffer RAM is read at acceptance with a same-cycle
// write bypass, so a request is taken every cycle while the response is drained.
// When rsp_ready stays low, the response register holds its beat, the input
// register holds the next request, and req_ready drops until the response moves.
// Reset (synchronous, active high) empties both pipeline registers, returns the
// deframer to header hunt, empties the mailbox, clears the error counter and all
// line flags. Line buffer contents are not cleared; no clearing pass is needed.

module tracking_packet_and_line_receiver
   import tplr_pkg::*;
#(
   parameter int LINE_DEPTH = 96
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [REQ_TYPE_W-1:0]     req_type,
   input  logic [DATA_W-1:0]         req_rx_data,
   input  logic [IDX_W-1:0]          req_line_index,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_packet_valid,
   output logic signed [COORD_W-1:0] rsp_target_x,
   output logic signed [COORD_W-1:0] rsp_target_y,
   output logic                      rsp_line_done,
   output logic [COUNT_W-1:0]        rsp_line_count,
   output logic [DATA_W-1:0]         rsp_line_char,
   output logic [TALLY_W-1:0]        rsp_bad_packets,
   output logic                      rsp_too_long
);

   logic               s1_valid_ff;
   req_kind_type       s1_type_ff;
   logic [DATA_W-1:0]  s1_data_ff;
   logic [IDX_W-1:0]   s1_index_ff;
   logic               accept;
   logic               fire;
   logic               out_free;
   frame_cmd_type      fcmd;
   frame_stat_type     fstat;
   line_cmd_type       lcmd;
   line_stat_type      lstat;
   logic               take_hit;

   // Handshake: the processing step fires when the response register can take a beat.
   assign out_free  = !rsp_valid || rsp_ready;
   assign fire      = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_type_ff  <= req_kind_type'(req_type);
         s1_data_ff  <= req_rx_data;
         s1_index_ff <= req_line_index;
      end
   end

   // Command decode for the deframer and the line store.
   assign fcmd.byte_en = fire && (s1_type_ff == REQ_BYTE);
   assign fcmd.take    = fire && (s1_type_ff == REQ_TAKE);
   assign fcmd.data    = s1_data_ff;

   assign lcmd.byte_en      = fcmd.byte_en && !fstat.consumed;
   assign lcmd.release_line = fire && (s1_type_ff == REQ_RELEASE);
   assign lcmd.clear_flag   = fire && (s1_type_ff != REQ_BYTE);
   assign lcmd.data         = s1_data_ff;

   tplr_deframer u_deframer (
      .clock (clock),
      .reset (reset),
      .cmd   (fcmd),
      .stat  (fstat)
   );

   tplr_line_store #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_line_store (
      .clock      (clock),
      .reset      (reset),
      .cmd        (lcmd),
      .rd_en      (accept),
      .rd_index   (req_line_index),
      .held_index (s1_index_ff),
      .stat       (lstat)
   );

   assign take_hit = (s1_type_ff == REQ_TAKE) && fstat.full;

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (out_free) begin
         rsp_valid <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_packet_valid <= take_hit;
         rsp_target_x     <= take_hit ? fstat.x : '0;
         rsp_target_y     <= take_hit ? fstat.y : '0;
         rsp_line_done    <= lstat.done_next;
         rsp_line_count   <= lstat.count_next;
         rsp_line_char    <= (s1_type_ff == REQ_READ) ? lstat.rd_char : '0;
         rsp_bad_packets  <= fstat.tally_next;
         rsp_too_long     <= (s1_type_ff == REQ_BYTE) ? lstat.ovf_next : lstat.ovf_now;
      end
   end

   // A held request survives a stalled response.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !fire) |=> s1_valid_ff)
      else $error("held request lost during stall");

   // A nonzero line length is reported only with a completed line.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_line_count != '0)) |-> rsp_line_done)
      else $error("line length without completed line");

   // A packet beat never carries a line character.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_packet_valid) |-> (rsp_line_char == '0))
      else $error("packet response with line character");

endmodule
